[hw/rtl/postfix_predicate_evaluator_defines.svh]
// Assertion macros for the postfix predicate evaluator.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef POSTFIX_PREDICATE_EVALUATOR_DEFINES_SVH
`define POSTFIX_PREDICATE_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define PPE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppe: same-cycle check failed");

// next-cycle implication
`define PPE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppe: next-cycle check failed");

`endif

[hw/rtl/ppe_pkg.sv]
// Package for the postfix predicate evaluator: operation codes and payload types.
// No dependencies.
package ppe_pkg;

  localparam logic [4:0] MODE_LOAD_VALUE  = 5'd0;
  localparam logic [4:0] MODE_LOAD_BOOL   = 5'd1;
  localparam logic [4:0] MODE_LOAD_HEADER = 5'd2;
  localparam logic [4:0] MODE_ADD         = 5'd3;
  localparam logic [4:0] MODE_EQ          = 5'd4;
  localparam logic [4:0] MODE_NEQ         = 5'd5;
  localparam logic [4:0] MODE_GT          = 5'd6;
  localparam logic [4:0] MODE_LT          = 5'd7;
  localparam logic [4:0] MODE_GE          = 5'd8;
  localparam logic [4:0] MODE_LE          = 5'd9;
  localparam logic [4:0] MODE_AND         = 5'd10;
  localparam logic [4:0] MODE_OR          = 5'd11;
  localparam logic [4:0] MODE_NOT         = 5'd12;
  localparam logic [4:0] MODE_BITAND      = 5'd13;
  localparam logic [4:0] MODE_BITOR       = 5'd14;
  localparam logic [4:0] MODE_BITXOR      = 5'd15;
  localparam logic [4:0] MODE_BITNOT      = 5'd16;
  localparam logic [4:0] MODE_VALID       = 5'd17;

  typedef struct packed {
    logic [4:0]  mode;
    logic [31:0] operand_value;
    logic        flag_value;
    logic        last_op;
  } in_item_t;

  typedef struct packed {
    logic predicate_true;
    logic stack_fault;
  } out_item_t;

endpackage

[hw/rtl/postfix_predicate_evaluator.sv]
// Postfix predicate evaluator: value, boolean and header-valid stacks in registers.
// Depends on ppe_pkg and postfix_predicate_evaluator_defines.svh.
//
// Usage:
//   in_valid/in_stall/in_item carry one postfix operation per transfer. A
//   transfer happens on a rising edge with valid high and stall low.
//   out_valid/out_stall/out_item carry one result per expression, produced
//   by the operation flagged last_op: the top boolean and a sticky fault bit
//   covering underflow and overflow of any stack in that expression.
//   Timing: an operation is registered on its input transfer and executed
//   against the stack tops in the following cycle, unless it is a last
//   operation held by a stall; its result then goes to the result register.
//   Throughput: one operation per cycle while in_stall is low, with one add
//   or compare per operation on the stack tops.
//   Stalls: while the result register is full and stalled, a pending last
//   operation waits and in_stall rises; other operations keep flowing.
//   Reset: synchronous, active low; empties all stacks, clears the fault
//   flag and drops any pending operation or result.
`include "postfix_predicate_evaluator_defines.svh"

module postfix_predicate_evaluator #(
  parameter int VALUE_WIDTH = 32,
  parameter int STACK_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ppe_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ppe_pkg::out_item_t   out_item
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] D_ZERO = '0;
  localparam logic [DW-1:0] D_ONE  = DW'(1);
  localparam logic [DW-1:0] D_TWO  = DW'(2);
  localparam logic [DW-1:0] D_FULL = DW'(STACK_DEPTH);

  logic                 s1_valid_r;
  ppe_pkg::in_item_t    s1_item_r;
  logic                 s1_go;
  logic                 out_valid_r;
  ppe_pkg::out_item_t   out_item_r;
  ppe_pkg::out_item_t   out_item_nxt;
  logic                 out_free;

  logic [VALUE_WIDTH-1:0] vstk_r   [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] vstk_nxt [STACK_DEPTH];
  logic                   tstk_r   [STACK_DEPTH];
  logic                   tstk_nxt [STACK_DEPTH];
  logic                   hstk_r   [STACK_DEPTH];
  logic                   hstk_nxt [STACK_DEPTH];
  logic [DW-1:0] vdep_r, vdep_nxt;
  logic [DW-1:0] tdep_r, tdep_nxt;
  logic [DW-1:0] hdep_r, hdep_nxt;
  logic          fault_r, fault_nxt;

  logic [VALUE_WIDTH+31:0] opnd_ext;
  logic [VALUE_WIDTH-1:0]  opnd;
  logic [VALUE_WIDTH-1:0]  v_l, v_r, v_sum;
  logic                    t_l, t_r, h_top, cmp_res;
  logic [DW-1:0]           v_pop1, v_pop2, t_pop1, t_pop2, h_pop1;
  logic                    cmp_fault;
  logic                    depth_ok;
  logic                    stacks_clear;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!s1_item_r.last_op || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  // ---------------------------------------------------------------------------
  // Stack tops and operation results
  // ---------------------------------------------------------------------------
  assign opnd_ext = {{VALUE_WIDTH{1'b0}}, s1_item_r.operand_value};
  assign opnd     = opnd_ext[VALUE_WIDTH-1:0];

  assign v_r    = (vdep_r >= D_ONE) ? vstk_r[0] : '0;
  assign v_l    = (vdep_r >= D_TWO) ? vstk_r[1] : '0;
  assign t_r    = (tdep_r >= D_ONE) ? tstk_r[0] : 1'b0;
  assign t_l    = (tdep_r >= D_TWO) ? tstk_r[1] : 1'b0;
  assign h_top  = (hdep_r >= D_ONE) ? hstk_r[0] : 1'b0;
  assign v_pop1 = (vdep_r >= D_ONE) ? vdep_r - D_ONE : D_ZERO;
  assign v_pop2 = (vdep_r >= D_TWO) ? vdep_r - D_TWO : D_ZERO;
  assign t_pop1 = (tdep_r >= D_ONE) ? tdep_r - D_ONE : D_ZERO;
  assign t_pop2 = (tdep_r >= D_TWO) ? tdep_r - D_TWO : D_ZERO;
  assign h_pop1 = (hdep_r >= D_ONE) ? hdep_r - D_ONE : D_ZERO;
  assign v_sum  = v_l + v_r;
  assign cmp_fault = (vdep_r < D_TWO);

  always_comb begin
    case (s1_item_r.mode)
      ppe_pkg::MODE_EQ:  cmp_res = (v_l == v_r);
      ppe_pkg::MODE_NEQ: cmp_res = (v_l != v_r);
      ppe_pkg::MODE_GT:  cmp_res = (v_l > v_r);
      ppe_pkg::MODE_LT:  cmp_res = (v_l < v_r);
      ppe_pkg::MODE_GE:  cmp_res = (v_l >= v_r);
      default:           cmp_res = (v_l <= v_r);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stack update
  // ---------------------------------------------------------------------------
  always_comb begin
    vstk_nxt     = vstk_r;
    tstk_nxt     = tstk_r;
    hstk_nxt     = hstk_r;
    vdep_nxt     = vdep_r;
    tdep_nxt     = tdep_r;
    hdep_nxt     = hdep_r;
    fault_nxt    = fault_r;
    out_item_nxt = '0;

    if (s1_go) begin
      unique case (s1_item_r.mode) inside
        ppe_pkg::MODE_LOAD_VALUE: begin
          if (vdep_r == D_FULL) begin
            fault_nxt = 1'b1;
          end else begin
            for (int i = 1; i < STACK_DEPTH; i++) vstk_nxt[i] = vstk_r[i-1];
            vstk_nxt[0] = opnd;
            vdep_nxt    = vdep_r + D_ONE;
          end
        end
        ppe_pkg::MODE_LOAD_BOOL: begin
          if (tdep_r == D_FULL) begin
            fault_nxt = 1'b1;
          end else begin
            for (int i = 1; i < STACK_DEPTH; i++) tstk_nxt[i] = tstk_r[i-1];
            tstk_nxt[0] = s1_item_r.flag_value;
            tdep_nxt    = tdep_r + D_ONE;
          end
        end
        ppe_pkg::MODE_LOAD_HEADER: begin
          if (hdep_r == D_FULL) begin
            fault_nxt = 1'b1;
          end else begin
            for (int i = 1; i < STACK_DEPTH; i++) hstk_nxt[i] = hstk_r[i-1];
            hstk_nxt[0] = s1_item_r.flag_value;
            hdep_nxt    = hdep_r + D_ONE;
          end
        end
        ppe_pkg::MODE_ADD, ppe_pkg::MODE_BITAND, ppe_pkg::MODE_BITOR,
        ppe_pkg::MODE_BITXOR: begin
          if (cmp_fault) fault_nxt = 1'b1;
          for (int i = 1; i + 1 < STACK_DEPTH; i++) vstk_nxt[i] = vstk_r[i+1];
          case (s1_item_r.mode)
            ppe_pkg::MODE_ADD:    vstk_nxt[0] = v_sum;
            ppe_pkg::MODE_BITAND: vstk_nxt[0] = v_l & v_r;
            ppe_pkg::MODE_BITOR:  vstk_nxt[0] = v_l | v_r;
            default:              vstk_nxt[0] = v_l ^ v_r;
          endcase
          vdep_nxt = v_pop2 + D_ONE;
        end
        ppe_pkg::MODE_EQ, ppe_pkg::MODE_NEQ, ppe_pkg::MODE_GT, ppe_pkg::MODE_LT,
        ppe_pkg::MODE_GE, ppe_pkg::MODE_LE: begin
          if (cmp_fault) fault_nxt = 1'b1;
          for (int i = 0; i + 2 < STACK_DEPTH; i++) vstk_nxt[i] = vstk_r[i+2];
          vdep_nxt = v_pop2;
          if (tdep_r == D_FULL) begin
            fault_nxt = 1'b1;
          end else begin
            for (int i = 1; i < STACK_DEPTH; i++) tstk_nxt[i] = tstk_r[i-1];
            tstk_nxt[0] = cmp_res;
            tdep_nxt    = tdep_r + D_ONE;
          end
        end
        ppe_pkg::MODE_AND, ppe_pkg::MODE_OR: begin
          if (tdep_r < D_TWO) fault_nxt = 1'b1;
          for (int i = 1; i + 1 < STACK_DEPTH; i++) tstk_nxt[i] = tstk_r[i+1];
          tstk_nxt[0] = (s1_item_r.mode == ppe_pkg::MODE_AND) ? (t_l & t_r) : (t_l | t_r);
          tdep_nxt    = t_pop2 + D_ONE;
        end
        ppe_pkg::MODE_NOT: begin
          if (tdep_r == D_ZERO) fault_nxt = 1'b1;
          tstk_nxt[0] = ~t_r;
          tdep_nxt    = t_pop1 + D_ONE;
        end
        ppe_pkg::MODE_BITNOT: begin
          if (vdep_r == D_ZERO) fault_nxt = 1'b1;
          vstk_nxt[0] = ~v_r;
          vdep_nxt    = v_pop1 + D_ONE;
        end
        ppe_pkg::MODE_VALID: begin
          if (hdep_r == D_ZERO) fault_nxt = 1'b1;
          for (int i = 0; i + 1 < STACK_DEPTH; i++) hstk_nxt[i] = hstk_r[i+1];
          hdep_nxt = h_pop1;
          if (tdep_r == D_FULL) begin
            fault_nxt = 1'b1;
          end else begin
            for (int i = 1; i < STACK_DEPTH; i++) tstk_nxt[i] = tstk_r[i-1];
            tstk_nxt[0] = h_top;
            tdep_nxt    = tdep_r + D_ONE;
          end
        end
        default: begin
        end
      endcase

      if (s1_item_r.last_op) begin
        out_item_nxt.predicate_true = (tdep_nxt != D_ZERO) ? tstk_nxt[0] : 1'b0;
        out_item_nxt.stack_fault    = fault_nxt || (tdep_nxt == D_ZERO);
        vdep_nxt  = D_ZERO;
        tdep_nxt  = D_ZERO;
        hdep_nxt  = D_ZERO;
        fault_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdep_r  <= D_ZERO;
      tdep_r  <= D_ZERO;
      hdep_r  <= D_ZERO;
      fault_r <= 1'b0;
    end else begin
      vdep_r  <= vdep_nxt;
      tdep_r  <= tdep_nxt;
      hdep_r  <= hdep_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vstk_r <= vstk_nxt;
    tstk_r <= tstk_nxt;
    hstk_r <= hstk_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_item_r.last_op) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.last_op) begin
      out_item_r <= out_item_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assign depth_ok     = (vdep_r <= D_FULL) && (tdep_r <= D_FULL) && (hdep_r <= D_FULL);
  assign stacks_clear = (vdep_r == D_ZERO) && (tdep_r == D_ZERO) && (hdep_r == D_ZERO)
                        && !fault_r;

  `PPE_ASSERT_IMP(a_depth_bound, 1'b1, depth_ok)
  `PPE_ASSERT_NXT(a_last_clears, s1_go && s1_item_r.last_op, out_valid_r && stacks_clear)
  `PPE_ASSERT_IMP(a_stall_cause, in_stall, s1_valid_r && s1_item_r.last_op && !out_free)

endmodule

[tb/sv/postfix_predicate_evaluator_tb.sv]
// Self-checking testbench for postfix_predicate_evaluator: directed and random postfix
// expressions, randomized stalls on both channels, verdicts checked against a local predictor.
// Depends on ppe_pkg and the postfix_predicate_evaluator RTL.
module postfix_predicate_evaluator_tb;

  localparam int VAL_W = 32;
  localparam int STK_D = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [4:0] UNKNOWN_MODE = 5'h1F;

  class verdict_predictor;
    logic [VAL_W-1:0] value_mem [STK_D];
    bit truth_mem [STK_D];
    bit header_mem [STK_D];
    int unsigned value_top;
    int unsigned truth_top;
    int unsigned header_top;
    bit fault_flag;
    ppe_pkg::out_item_t pending_verdicts [$];
    int unsigned errors;
    int unsigned verdicts;
    int unsigned faulted;

    function void push_value(input logic [VAL_W-1:0] v);
      if (value_top >= STK_D) begin
        fault_flag = 1'b1;
      end else begin
        value_mem[value_top] = v;
        value_top++;
      end
    endfunction

    function logic [VAL_W-1:0] pop_value();
      if (value_top == 0) begin
        fault_flag = 1'b1;
        return '0;
      end
      value_top--;
      return value_mem[value_top];
    endfunction

    function void push_truth(input bit b);
      if (truth_top >= STK_D) begin
        fault_flag = 1'b1;
      end else begin
        truth_mem[truth_top] = b;
        truth_top++;
      end
    endfunction

    function bit pop_truth();
      if (truth_top == 0) begin
        fault_flag = 1'b1;
        return 1'b0;
      end
      truth_top--;
      return truth_mem[truth_top];
    endfunction

    function void note_op(input ppe_pkg::in_item_t it);
      logic [VAL_W-1:0] lhs;
      logic [VAL_W-1:0] rhs;
      bit lb;
      bit rb;
      ppe_pkg::out_item_t res;
      lhs = '0;
      rhs = '0;
      case (it.mode) inside
        ppe_pkg::MODE_ADD, ppe_pkg::MODE_EQ, ppe_pkg::MODE_NEQ, ppe_pkg::MODE_GT,
        ppe_pkg::MODE_LT, ppe_pkg::MODE_GE, ppe_pkg::MODE_LE, ppe_pkg::MODE_BITAND,
        ppe_pkg::MODE_BITOR, ppe_pkg::MODE_BITXOR: begin
          rhs = pop_value();
          lhs = pop_value();
        end
        default: ;
      endcase
      case (it.mode)
        ppe_pkg::MODE_LOAD_VALUE:  push_value(it.operand_value);
        ppe_pkg::MODE_LOAD_BOOL:   push_truth(it.flag_value);
        ppe_pkg::MODE_LOAD_HEADER: begin
          if (header_top >= STK_D) begin
            fault_flag = 1'b1;
          end else begin
            header_mem[header_top] = it.flag_value;
            header_top++;
          end
        end
        ppe_pkg::MODE_ADD:    push_value(lhs + rhs);
        ppe_pkg::MODE_EQ:     push_truth(lhs == rhs);
        ppe_pkg::MODE_NEQ:    push_truth(lhs != rhs);
        ppe_pkg::MODE_GT:     push_truth(lhs > rhs);
        ppe_pkg::MODE_LT:     push_truth(lhs < rhs);
        ppe_pkg::MODE_GE:     push_truth(lhs >= rhs);
        ppe_pkg::MODE_LE:     push_truth(lhs <= rhs);
        ppe_pkg::MODE_AND: begin
          rb = pop_truth();
          lb = pop_truth();
          push_truth(lb & rb);
        end
        ppe_pkg::MODE_OR: begin
          rb = pop_truth();
          lb = pop_truth();
          push_truth(lb | rb);
        end
        ppe_pkg::MODE_NOT:    push_truth(~pop_truth());
        ppe_pkg::MODE_BITAND: push_value(lhs & rhs);
        ppe_pkg::MODE_BITOR:  push_value(lhs | rhs);
        ppe_pkg::MODE_BITXOR: push_value(lhs ^ rhs);
        ppe_pkg::MODE_BITNOT: push_value(~pop_value());
        ppe_pkg::MODE_VALID: begin
          if (header_top == 0) begin
            fault_flag = 1'b1;
            rb = 1'b0;
          end else begin
            header_top--;
            rb = header_mem[header_top];
          end
          push_truth(rb);
        end
        default: ;
      endcase
      if (it.last_op) begin
        if (truth_top == 0) begin
          fault_flag = 1'b1;
          res.predicate_true = 1'b0;
        end else begin
          res.predicate_true = truth_mem[truth_top - 1];
        end
        res.stack_fault = fault_flag;
        pending_verdicts = {pending_verdicts, res};
        value_top = 0;
        truth_top = 0;
        header_top = 0;
        fault_flag = 1'b0;
      end
    endfunction

    function void check_verdict(input ppe_pkg::out_item_t got);
      ppe_pkg::out_item_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict: expected none, actual true=%0b fault=%0b",
                 $time, got.predicate_true, got.stack_fault);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts++;
      if (want.stack_fault) faulted++;
      if (got.predicate_true !== want.predicate_true) begin
        $display("%0t: predicate_true mismatch: expected %0b, actual %0b",
                 $time, want.predicate_true, got.predicate_true);
        errors++;
      end
      if (got.stack_fault !== want.stack_fault) begin
        $display("%0t: stack_fault mismatch: expected %0b, actual %0b",
                 $time, want.stack_fault, got.stack_fault);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ppe_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ppe_pkg::out_item_t out_item;

  verdict_predictor predictor = new();
  bit quiet = 1'b0;
  bit long_hold_done = 1'b0;
  int unsigned op_count = 0;
  int unsigned cycle_count = 0;

  postfix_predicate_evaluator #(
    .VALUE_WIDTH(VAL_W),
    .STACK_DEPTH(STK_D)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("postfix_predicate_evaluator verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) predictor.check_verdict(out_item);
  end

  // receiver: random stall bursts, one long hold-off once verdicts are flowing
  initial begin
    forever begin
      @(negedge clk);
      if (!long_hold_done && predictor.verdicts >= 20) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic ppe_pkg::in_item_t make_op(input logic [4:0] m, input logic [31:0] v,
                                                input logic f, input logic l);
    ppe_pkg::in_item_t it;
    it.mode = m;
    it.operand_value = v;
    it.flag_value = f;
    it.last_op = l;
    return it;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);
      3: return 32'h8000_0000 | $urandom_range(0, 1);
      default: return $urandom;
    endcase
  endfunction

  // apply one operation to tracked depths; reject anything that would fault
  function automatic bit legal_step(input logic [4:0] m, inout int vd, inout int td,
                                    inout int hd);
    case (m) inside
      ppe_pkg::MODE_LOAD_VALUE: begin
        if (vd >= STK_D) return 1'b0;
        vd++;
      end
      ppe_pkg::MODE_LOAD_BOOL: begin
        if (td >= STK_D) return 1'b0;
        td++;
      end
      ppe_pkg::MODE_LOAD_HEADER: begin
        if (hd >= STK_D) return 1'b0;
        hd++;
      end
      ppe_pkg::MODE_ADD, ppe_pkg::MODE_BITAND, ppe_pkg::MODE_BITOR,
      ppe_pkg::MODE_BITXOR: begin
        if (vd < 2) return 1'b0;
        vd--;
      end
      ppe_pkg::MODE_EQ, ppe_pkg::MODE_NEQ, ppe_pkg::MODE_GT, ppe_pkg::MODE_LT,
      ppe_pkg::MODE_GE, ppe_pkg::MODE_LE: begin
        if (vd < 2 || td >= STK_D) return 1'b0;
        vd -= 2;
        td++;
      end
      ppe_pkg::MODE_AND, ppe_pkg::MODE_OR: begin
        if (td < 2) return 1'b0;
        td--;
      end
      ppe_pkg::MODE_NOT: begin
        if (td < 1) return 1'b0;
      end
      ppe_pkg::MODE_BITNOT: begin
        if (vd < 1) return 1'b0;
      end
      ppe_pkg::MODE_VALID: begin
        if (hd < 1 || td >= STK_D) return 1'b0;
        hd--;
        td++;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(input ppe_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.note_op(it);
    op_count++;
    @(negedge clk);
  endtask

  task automatic send_expression();
    int vd;
    int td;
    int hd;
    int nvd;
    int ntd;
    int nhd;
    int len;
    int kind;
    logic [4:0] flood_mode;
    logic [4:0] cand [$];
    ppe_pkg::in_item_t it;
    vd = 0;
    td = 0;
    hd = 0;
    kind = $urandom_range(0, 19);
    case ($urandom_range(0, 2))
      0: flood_mode = ppe_pkg::MODE_LOAD_VALUE;
      1: flood_mode = ppe_pkg::MODE_LOAD_BOOL;
      default: flood_mode = ppe_pkg::MODE_LOAD_HEADER;
    endcase
    if (kind == 2) len = $urandom_range(STK_D + 1, STK_D + 3);
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(10, 24);
    else len = $urandom_range(1, 9);
    for (int k = 0; k < len; k++) begin
      it.operand_value = pick_operand();
      it.flag_value = 1'($urandom_range(0, 1));
      it.last_op = (k == len - 1);
      if (kind < 2 || (kind == 2 && it.last_op)) begin
        it.mode = 5'($urandom_range(0, 31));
      end else if (kind == 2) begin
        it.mode = flood_mode;
      end else begin
        cand.delete();
        for (int m = 0; m <= ppe_pkg::MODE_VALID; m++) begin
          nvd = vd;
          ntd = td;
          nhd = hd;
          if (legal_step(5'(m), nvd, ntd, nhd) && (!it.last_op || ntd > 0)) begin
            cand = {cand, 5'(m)};
          end
        end
        it.mode = cand[$urandom_range(0, cand.size() - 1)];
        void'(legal_step(it.mode, vd, td, hd));
      end
      send_item(it);
    end
  endtask

  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (predictor.pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // wrapping add, complement, unsigned compare at the extremes
    send_item(make_op(ppe_pkg::MODE_LOAD_VALUE, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_LOAD_VALUE, 32'h0000_0001, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_ADD, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_BITNOT, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_LOAD_VALUE, 32'h0000_0000, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_GE, 32'h0, 1'b0, 1'b1));
    // header valid and boolean logic
    send_item(make_op(ppe_pkg::MODE_LOAD_HEADER, 32'h0, 1'b1, 1'b0));
    send_item(make_op(ppe_pkg::MODE_VALID, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_LOAD_BOOL, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_OR, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_NOT, 32'h0, 1'b0, 1'b1));
    // underflow on empty stacks
    send_item(make_op(ppe_pkg::MODE_EQ, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_NEQ, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_LT, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_LE, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_AND, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_BITAND, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_BITOR, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_BITXOR, 32'h0, 1'b0, 1'b0));
    send_item(make_op(ppe_pkg::MODE_GT, 32'h0, 1'b0, 1'b1));
    // boolean stack overflow
    for (int k = 0; k <= STK_D; k++) begin
      send_item(make_op(ppe_pkg::MODE_LOAD_BOOL, 32'h0, 1'b1, k == STK_D));
    end
    // unknown mode as the only operation: empty boolean stack at the end
    send_item(make_op(UNKNOWN_MODE, 32'hFFFF_FFFF, 1'b1, 1'b1));
    wait_for_verdicts();

    while (op_count < 500) send_expression();
    wait_for_verdicts();
    while (op_count < 950) send_expression();
    quiet = 1'b1;
    while (op_count < 1050) send_expression();
    wait_for_verdicts();
    repeat (10) @(posedge clk);

    $display("run covered %0d operations in %0d expressions, %0d ending with a stack fault",
             op_count, predictor.verdicts, predictor.faulted);
    $display("long receiver hold-off exercised: %0b, cycles used: %0d",
             long_hold_done, cycle_count);
    if (predictor.errors == 0 && predictor.pending_verdicts.size() == 0) begin
      $display("postfix_predicate_evaluator verification clean");
    end else begin
      $display("postfix_predicate_evaluator verification failed");
    end
    $finish;
  end
endmodule
